/* design/edge_clamped_box_blur_top_macros.svh */
// Assertion helpers for the box blur block.
`ifndef EDGE_CLAMPED_BOX_BLUR_TOP_MACROS_SVH
`define EDGE_CLAMPED_BOX_BLUR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ECBB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ECBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/ecbb_pkg.sv */
`timescale 1ns / 1ps

package ecbb_pkg;

   // Sample and radius widths are fixed by the stream format.
   localparam int SAMPLE_BITS        = 16;
   localparam int RADIUS_BITS        = 6;
   localparam int MAX_RADIUS_DEFAULT = 63;

   // Input transaction payload.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_in;
      logic                   last_in;
   } req_payload_type;

   // Output transaction payload.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] avg_out;
      logic                   last_out;
   } rsp_payload_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic accept;      // take sample, write history, read oldest
      logic update;      // fold sample into sum and counts
      logic start_div;   // launch mean division
      logic emit;        // load output register, retire one pending output
      logic left_inc;    // saturating left edge count increment
      logic drop_issue;  // read oldest history entry
      logic drop_sub;    // remove oldest entry from the window
      logic clear;       // end of line
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic last;        // current sample closes the line
      logic pend_nz;
      logic pend_gt_r;
      logic left_ge_r;
      logic seen_nz;
      logic div_done;
      logic out_free;    // output register can take a result this cycle
   } ctrl_status_type;

endpackage

/* design/edge_clamped_box_blur_top.sv */
`timescale 1ns / 1ps
// Edge-clamped box blur over one line of samples.
// req_*: one sample transaction per line sample; last_in closes the line.
// rsp_*: windowed means, rounded to nearest; last_out marks the line's final mean.
// csr_*: write of the window radius (always ready); it also drops the line in
//   progress, so write it only with the block idle.
// Output i leaves once sample i+radius is in; the last sample flushes the rest.
// Sequence: a sample passes through accept, window update and decision when
//   it yields no result. A result adds a bit-serial restoring division of the
//   SAMPLE_BITS + clog2(2*MAX_RADIUS+2) bit sum, then an emit step.
//   During a flush each further result costs the division, the emit, a
//   history read when the window slides, and a decision. The divider and the
//   single history read port set the pace.
// The output register decouples the sides: the block takes the next sample
//   while a result waits, and holds before emitting another until the receiver
//   takes the first.
// Reset: radius 0 (each sample returns itself), line empty, no result pending.
//   The history memory needs no clearing pass; only written entries are used.

`include "edge_clamped_box_blur_top_macros.svh"

module edge_clamped_box_blur_top #(
   parameter int MAX_RADIUS = ecbb_pkg::MAX_RADIUS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ecbb_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ecbb_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ecbb_pkg::RADIUS_BITS-1:0] csr_data
);

   ecbb_pkg::ctrl_cmd_type    cmd;
   ecbb_pkg::ctrl_status_type status;

   assign csr_ready = 1'b1;

   // Sequencer
   ecbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Window, divider and output register
   ecbb_datapath #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status)
   );

   // Checks
   `ECBB_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, status.out_free, "result overwrote a waiting result")
   `ECBB_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "sample taken while one is in work")
   `ECBB_ASSERT_IMPLY(a_div_busy, clock, reset, status.div_done, !req_ready, "divider result pending in idle")

endmodule

/* design/ecbb_ram.sv */
`timescale 1ns / 1ps

module ecbb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ecbb_ctrl.sv */
`timescale 1ns / 1ps

module ecbb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ecbb_pkg::ctrl_status_type status,
   output ecbb_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_DROP   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.last) begin
               if (status.pend_nz) begin
                  cmd.start_div = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (status.pend_gt_r) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_done && status.out_free) begin
               cmd.emit = 1'b1;
               if (!status.last) begin
                  cmd.left_inc = 1'b1;
                  state_in     = ST_IDLE;
               end else if (status.left_ge_r) begin
                  // flush: window slides right past the line end
                  if (status.seen_nz) begin
                     cmd.drop_issue = 1'b1;
                     state_in       = ST_DROP;
                  end else begin
                     state_in = ST_DECIDE;
                  end
               end else begin
                  cmd.left_inc = 1'b1;
                  state_in     = ST_DECIDE;
               end
            end
         end
         ST_DROP: begin
            cmd.drop_sub = 1'b1;
            state_in     = ST_DECIDE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/ecbb_datapath.sv */
`timescale 1ns / 1ps

module ecbb_datapath #(
   parameter int MAX_RADIUS = ecbb_pkg::MAX_RADIUS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ecbb_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ecbb_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_valid,
   input  logic [ecbb_pkg::RADIUS_BITS-1:0]    csr_data,
   input  ecbb_pkg::ctrl_cmd_type              cmd,
   output ecbb_pkg::ctrl_status_type           status
);

   localparam int SB    = ecbb_pkg::SAMPLE_BITS;
   localparam int RB    = ecbb_pkg::RADIUS_BITS;
   localparam int CW    = $clog2(2 * MAX_RADIUS + 2);  // holds 2r+1
   localparam int AW    = CW;
   localparam int DEPTH = 1 << AW;
   localparam int SW    = SB + CW;                     // running sum width
   localparam int DCW   = $clog2(SW + 1);
   localparam logic [RB-1:0] RMAX = RB'(MAX_RADIUS);

   logic [RB-1:0] radius_ff, radius_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] seen_ff, seen_in;
   logic [CW-1:0] pend_ff, pend_in;
   logic [CW-1:0] left_ff, left_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [SB-1:0] sample_ff;
   logic          last_ff;
   logic          drop_ff;

   logic [RB-1:0] r_sel;
   logic [CW-1:0] r_eff;
   logic [CW-1:0] win_max;
   logic          drop_needed;
   logic [SB-1:0] ram_rdata;
   logic [AW-1:0] rd_addr;

   // divider registers
   logic           div_run_ff, div_run_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic [SW-1:0]  div_num_ff, div_num_in;
   logic [CW-1:0]  div_rem_ff, div_rem_in;
   logic [CW-1:0]  div_den_ff;
   logic           div_zero_ff;
   logic [CW:0]    rem_sh;
   logic [CW:0]    den_ext;
   logic [CW:0]    rem_sub;
   logic           rem_ge;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   ecbb_pkg::rsp_payload_type rsp_data_ff;

   // Effective radius and window limits
   assign r_sel       = (radius_ff > RMAX) ? RMAX : radius_ff;
   assign r_eff       = CW'(r_sel);
   assign win_max     = CW'({r_eff, 1'b1});
   assign drop_needed = seen_ff >= win_max;
   assign rd_addr     = wp_ff - seen_ff;

   // History ring
   ecbb_ram #(
      .WIDTH (SB),
      .DEPTH (DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wp_ff),
      .wr_data (req_payload.sample_in),
      .rd_en   (cmd.accept || cmd.drop_issue),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Window state next values
   always_comb begin
      radius_in = radius_ff;
      sum_in    = sum_ff;
      seen_in   = seen_ff;
      pend_in   = pend_ff;
      left_in   = left_ff;
      wp_in     = wp_ff;
      if (csr_valid || cmd.clear) begin
         if (csr_valid) begin
            radius_in = csr_data;
         end
         sum_in  = '0;
         seen_in = '0;
         pend_in = '0;
         left_in = '0;
         wp_in   = '0;
      end else begin
         if (cmd.accept) begin
            wp_in = wp_ff + AW'(1);
         end
         if (cmd.update) begin
            sum_in  = sum_ff + SW'(sample_ff) - (drop_ff ? SW'(ram_rdata) : '0);
            seen_in = drop_ff ? seen_ff : seen_ff + CW'(1);
            pend_in = pend_ff + CW'(1);
         end
         if (cmd.drop_sub) begin
            sum_in  = sum_ff - SW'(ram_rdata);
            seen_in = seen_ff - CW'(1);
         end
         if (cmd.emit) begin
            pend_in = pend_ff - CW'(1);
         end
         if (cmd.left_inc && (left_ff < r_eff)) begin
            left_in = left_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         sum_ff    <= '0;
         seen_ff   <= '0;
         pend_ff   <= '0;
         left_ff   <= '0;
         wp_ff     <= '0;
      end else begin
         radius_ff <= radius_in;
         sum_ff    <= sum_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
         left_ff   <= left_in;
         wp_ff     <= wp_in;
      end
   end

   // Latched sample transaction
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_payload.sample_in;
         last_ff   <= req_payload.last_in;
         drop_ff   <= drop_needed;
      end
   end

   // Restoring divider, one quotient bit a cycle
   assign rem_sh  = {div_rem_ff, div_num_ff[SW-1]};
   assign den_ext = {1'b0, div_den_ff};
   assign rem_sub = rem_sh - den_ext;
   assign rem_ge  = rem_sh >= den_ext;

   always_comb begin
      div_run_in = div_run_ff;
      div_cnt_in = div_cnt_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      if (cmd.start_div) begin
         div_run_in = 1'b1;
         div_cnt_in = DCW'(SW);
         div_num_in = sum_ff + SW'(seen_ff >> 1);
         div_rem_in = '0;
      end else if (cmd.emit) begin
         div_run_in = 1'b0;
      end else if (div_run_ff && (div_cnt_ff != '0)) begin
         div_cnt_in = div_cnt_ff - DCW'(1);
         div_num_in = {div_num_ff[SW-2:0], rem_ge};
         div_rem_in = rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0;
      end else begin
         div_run_ff <= div_run_in;
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff <= div_cnt_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      if (cmd.start_div) begin
         div_den_ff  <= seen_ff;
         div_zero_ff <= (seen_ff == '0);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.avg_out  <= div_zero_ff ? '0 : div_num_ff[SB-1:0];
         rsp_data_ff.last_out <= last_ff && (pend_ff == CW'(1));
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Status to controller
   assign status.last      = last_ff;
   assign status.pend_nz   = pend_ff != '0;
   assign status.pend_gt_r = pend_ff > r_eff;
   assign status.left_ge_r = left_ff >= r_eff;
   assign status.seen_nz   = seen_ff != '0;
   assign status.div_done  = div_run_ff && (div_cnt_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule
